/* hw/rtl/gar_pkg.sv */
// Package for the group average restriction block: widths, register codes
// and the helper functions for the steering table. No dependencies.
`timescale 1ns / 1ps

package gar_pkg;

  localparam int MaxCoarse = 16;
  localparam int ValueW    = 32;
  localparam int SumW      = 40;
  localparam int SizeW     = 8;
  localparam int GroupW    = 4;
  localparam int CountW    = 5;
  localparam int CfgDataW  = 64;
  localparam int CfgAddrW  = 5;
  localparam int DivCntW   = $clog2(SumW + 1);

  typedef enum logic [1:0] {
    REG_SIZES_LOW   = 2'd0,
    REG_SIZES_HIGH  = 2'd1,
    REG_GROUP_COUNT = 2'd2
  } cfg_reg_e;

  // Fine count of one coarse group; a count of zero acts as one.
  function automatic logic [SizeW-1:0] run_size(input logic [CfgDataW-1:0] lo,
                                                 input logic [CfgDataW-1:0] hi,
                                                 input logic [GroupW-1:0]   grp);
    logic [CfgDataW-1:0] word;
    logic [SizeW-1:0]    sz;
    word = grp[GroupW-1] ? hi : lo;
    sz   = word[grp[GroupW-2:0]*SizeW +: SizeW];
    return (sz == '0) ? SizeW'(1) : sz;
  endfunction

  // Coarse groups in use, clamped to the range one to MaxCoarse.
  function automatic logic [CountW-1:0] groups_in_use(input logic [CountW-1:0] cnt);
    logic [CountW-1:0] n;
    n = cnt;
    if (n == '0) begin
      n = CountW'(1);
    end
    if (n > CountW'(MaxCoarse)) begin
      n = CountW'(MaxCoarse);
    end
    return n;
  endfunction

endpackage

/* hw/rtl/gar_in_if.sv */
// Input channel of the group average restriction block: one fine value a beat.
// Depends on gar_pkg.
`timescale 1ns / 1ps

interface gar_in_if import gar_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ValueW-1:0] fine_value;

  modport source (output valid, output fine_value, input ready);
  modport sink   (input valid, input fine_value, output ready);
endinterface

/* hw/rtl/gar_out_if.sv */
// Output channel of the group average restriction block: one coarse mean a beat.
// Depends on gar_pkg.
`timescale 1ns / 1ps

interface gar_out_if import gar_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ValueW-1:0] coarse_mean;
  logic [GroupW-1:0]        coarse_index;
  logic                     last_of_unknown;

  modport source (output valid, output coarse_mean, output coarse_index,
                  output last_of_unknown, input ready);
  modport sink   (input valid, input coarse_mean, input coarse_index,
                  input last_of_unknown, output ready);
endinterface

/* hw/rtl/gar_div.sv */
// Bit-serial restoring divider: signed run sum by an unsigned run size,
// one quotient bit per cycle, truncated toward zero. Depends on gar_pkg.
`timescale 1ns / 1ps

module gar_div import gar_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [SumW-1:0]   dividend_i,
  input  logic [SizeW-1:0]         divisor_i,
  output logic                     busy_o,
  output logic signed [ValueW-1:0] quotient_o
);

  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [SumW-1:0]    shreg_q, shreg_d;
  logic [SizeW-1:0]   rem_q, rem_d;
  logic [SizeW-1:0]   divisor_q;
  logic               neg_q;
  logic [SizeW:0]     trial;
  logic [SizeW:0]     diff;
  logic               ge;

  // The dividend shifts out at the top while quotient bits shift in below.
  assign trial = {rem_q, shreg_q[SumW-1]};
  assign diff  = trial - {1'b0, divisor_q};
  assign ge    = trial >= {1'b0, divisor_q};

  always_comb begin
    cnt_d   = cnt_q;
    shreg_d = shreg_q;
    rem_d   = rem_q;
    if (start_i) begin
      cnt_d   = DivCntW'(SumW);
      shreg_d = dividend_i[SumW-1] ? (~dividend_i + SumW'(1)) : dividend_i;
      rem_d   = '0;
    end else if (cnt_q != '0) begin
      cnt_d   = cnt_q - DivCntW'(1);
      shreg_d = {shreg_q[SumW-2:0], ge};
      rem_d   = ge ? diff[SizeW-1:0] : trial[SizeW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shreg_q <= shreg_d;
    rem_q   <= rem_d;
    if (start_i) begin
      divisor_q <= divisor_i;
      neg_q     <= dividend_i[SumW-1];
    end
  end

  assign busy_o     = cnt_q != '0;
  assign quotient_o = neg_q ? (~shreg_q[ValueW-1:0] + ValueW'(1)) : shreg_q[ValueW-1:0];

endmodule

/* hw/rtl/group_average_restriction.sv */
// A beat that closes a run moves the block from S_IDLE to S_START, where the
// 40-step bit-serial divider takes the run sum, then via S_DIV to S_OUT, which
// registers the coarse mean; a beat that leaves the run open gives nothing. Input
// is taken one beat a cycle inside a run, none from a closing beat until its mean
// is registered. A waiting result blocks input only once the next run's mean is ready.
// Reset clears the run sum, run count and group counter; sizes read 0, count 1.
`timescale 1ns / 1ps

module group_average_restriction import gar_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  gar_in_if.sink              in_if,
  gar_out_if.source           out_if,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_DIV,
    S_OUT
  } state_e;

  state_e state_q, state_d;

  logic [CfgDataW-1:0] sizes_low_q, sizes_high_q;
  logic [CountW-1:0]   group_count_q;

  logic signed [SumW-1:0] sum_q, sum_d;
  logic [SizeW-1:0]       fig_q, fig_d;
  logic [GroupW-1:0]      cur_q, cur_d;

  logic [GroupW-1:0]   grp_q;
  logic                last_q;
  logic [SizeW-1:0]    size_q;

  logic                     out_valid_q, out_valid_d;
  logic signed [ValueW-1:0] mean_q;
  logic [GroupW-1:0]        idx_q;
  logic                     out_last_q;

  logic                   in_fire;
  logic                   out_load;
  logic [SizeW-1:0]       cur_size;
  logic [CountW-1:0]      n_groups;
  logic                   cur_last;
  logic signed [SumW-1:0] sum_next;
  logic [SizeW-1:0]       fig_next;
  logic                   closes;
  logic                   cfg_wr;
  cfg_reg_e               cfg_sel;

  logic                     div_start;
  logic                     div_busy;
  logic signed [ValueW-1:0] div_quot;

  // Configuration port.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = cfg_reg_e'(paddr[CfgAddrW-1:3]);

  always_comb begin
    unique case (cfg_sel)
      REG_SIZES_LOW:   prdata = sizes_low_q;
      REG_SIZES_HIGH:  prdata = sizes_high_q;
      REG_GROUP_COUNT: prdata = CfgDataW'(group_count_q);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sizes_low_q   <= '0;
      sizes_high_q  <= '0;
      group_count_q <= CountW'(1);
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_SIZES_LOW:   sizes_low_q   <= pwdata;
        REG_SIZES_HIGH:  sizes_high_q  <= pwdata;
        REG_GROUP_COUNT: group_count_q <= pwdata[CountW-1:0];
        default:         ;
      endcase
    end
  end

  // Run accumulation.
  assign cur_size = run_size(sizes_low_q, sizes_high_q, cur_q);
  assign n_groups = groups_in_use(group_count_q);
  assign cur_last = (CountW'(cur_q) + CountW'(1)) >= n_groups;
  assign sum_next = sum_q + {{(SumW-ValueW){in_if.fine_value[ValueW-1]}}, in_if.fine_value};
  assign fig_next = fig_q + SizeW'(1);
  assign closes   = fig_next >= cur_size;

  assign in_if.ready = state_q == S_IDLE;
  assign in_fire     = in_if.valid && in_if.ready;
  assign div_start   = state_q == S_START;
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || out_if.ready);

  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    fig_d       = fig_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_if.ready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          sum_d = sum_next;
          fig_d = fig_next;
          if (closes) begin
            state_d = S_START;
          end
        end
      end
      S_START: begin
        // The divider has taken the sum, so the next run can open now.
        sum_d   = '0;
        fig_d   = '0;
        cur_d   = last_q ? '0 : grp_q + GroupW'(1);
        state_d = S_DIV;
      end
      S_DIV: begin
        if (!div_busy) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sum_q       <= '0;
      fig_q       <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      fig_q       <= fig_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && closes) begin
      grp_q  <= cur_q;
      last_q <= cur_last;
      size_q <= cur_size;
    end
    if (out_load) begin
      mean_q     <= div_quot;
      idx_q      <= grp_q;
      out_last_q <= last_q;
    end
  end

  gar_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (size_q),
    .busy_o     (div_busy),
    .quotient_o (div_quot)
  );

  assign out_if.valid           = out_valid_q;
  assign out_if.coarse_mean     = mean_q;
  assign out_if.coarse_index    = idx_q;
  assign out_if.last_of_unknown = out_last_q;

  // No beat is taken while the divider works on a run.
  assert property (@(posedge clk_i) disable iff (!rst_ni) div_busy |-> !in_if.ready)
    else $error("input accepted while divider busy");

  // A new result appears only after the divide has finished.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT) && $past(!div_busy))
    else $error("result loaded before divide finished");

  // Handing a run to the divider clears the run state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_START |=> fig_q == '0 && sum_q == '0)
    else $error("run state not cleared after close");

endmodule

/* dv/group_average_restriction_tb.sv */
// Testbench for group_average_restriction: a directed table, then random phases of
// fine values under several steering tables, checked against an in-bench predictor.
// Depends on gar_pkg, gar_in_if, gar_out_if and the block itself.
`timescale 1ns / 1ps

module group_average_restriction_tb;
  import gar_pkg::*;

  localparam int CycleLimit = 600_000;
  localparam int SettleCycles = 48;

  typedef struct packed {
    logic signed [ValueW-1:0] coarse_mean;
    logic [GroupW-1:0]        coarse_index;
    logic                     last_of_unknown;
  } coarse_beat_t;

  typedef enum { ROW_WRITE, ROW_FINE, ROW_MEAN } plan_kind_e;

  typedef struct {
    plan_kind_e    kind;
    cfg_reg_e      which;
    logic [63:0]   data;
    coarse_beat_t  want;
  } plan_row_t;

  typedef enum { MIX_SMALL, MIX_UNIT, MIX_WIDE, MIX_BIG } size_mix_e;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  gar_in_if  in_if ();
  gar_out_if out_if ();

  group_average_restriction uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk_i = ~clk_i;

  // Predictor copy of the configuration and of the open run.
  logic [CfgDataW-1:0] sizes_lo_m = '0;
  logic [CfgDataW-1:0] sizes_hi_m = '0;
  logic [CountW-1:0]   groups_m   = CountW'(1);
  longint              open_sum   = 0;
  logic [SizeW-1:0]    open_taken = '0;
  logic [GroupW-1:0]   open_group = '0;

  coarse_beat_t means_due[$];
  plan_row_t    plan[$];
  int           mismatches = 0;
  int           fine_sent  = 0;
  int           cycle_count = 0;
  int           stall_left = 0;
  bit           steady = 1'b0;
  bit           tail_quiet = 1'b0;
  coarse_beat_t head_mean;

  // Adds one fine value to the open run; returns 1 with the coarse beat when the
  // run closes.
  function automatic bit accumulate_fine(input logic signed [ValueW-1:0] v,
                                         output coarse_beat_t r);
    logic [CfgDataW-1:0] word;
    logic [SizeW-1:0]    len;
    int                  span;
    longint              q;
    r    = '0;
    word = open_group[GroupW-1] ? sizes_hi_m : sizes_lo_m;
    len  = word[open_group[GroupW-2:0]*SizeW +: SizeW];
    if (len == '0) begin
      len = SizeW'(1);
    end
    span = (groups_m == '0) ? 1 : int'(groups_m);
    if (span > MaxCoarse) begin
      span = MaxCoarse;
    end
    open_sum   += longint'(v);
    open_taken = open_taken + 1'b1;
    if (open_taken < len) begin
      return 1'b0;
    end
    q = open_sum / longint'(len);
    r.coarse_mean     = q[ValueW-1:0];
    r.coarse_index    = open_group;
    r.last_of_unknown = (int'(open_group) + 1 >= span);
    open_sum   = 0;
    open_taken = '0;
    open_group = r.last_of_unknown ? '0 : open_group + 1'b1;
    return 1'b1;
  endfunction

  function automatic logic [ValueW-1:0] pick_fine();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($urandom_range(0, 511) - 256);
      3: return 32'($urandom_range(0, 8) * 32'h0001_0000 - 32'h0004_0000);
      default: return $urandom;
    endcase
  endfunction

  task automatic plan_write(input cfg_reg_e which, input logic [63:0] data);
    plan_row_t row;
    row.kind  = ROW_WRITE;
    row.which = which;
    row.data  = data;
    row.want  = '0;
    plan.push_back(row);
  endtask

  task automatic plan_fine(input logic [ValueW-1:0] v);
    plan_row_t row;
    row.kind  = ROW_FINE;
    row.which = REG_SIZES_LOW;
    row.data  = 64'(v);
    row.want  = '0;
    plan.push_back(row);
  endtask

  task automatic plan_mean(input logic [ValueW-1:0] v, input logic [ValueW-1:0] mean,
                           input logic [GroupW-1:0] idx, input logic last);
    plan_row_t row;
    row.kind  = ROW_MEAN;
    row.which = REG_SIZES_LOW;
    row.data  = 64'(v);
    row.want.coarse_mean     = mean;
    row.want.coarse_index    = idx;
    row.want.last_of_unknown = last;
    plan.push_back(row);
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic push_fine(input logic [ValueW-1:0] v, input bit typed,
                           input coarse_beat_t want);
    coarse_beat_t got;
    bit           made;
    in_if.valid      <= 1'b1;
    in_if.fine_value <= v;
    do @(posedge clk_i); while (!in_if.ready);
    made = accumulate_fine(v, got);
    // A typed-in row carries its own expected beat in place of the predictor's.
    if (typed) begin
      means_due.push_back(want);
    end else if (made) begin
      means_due.push_back(got);
    end
    fine_sent++;
    @(negedge clk_i);
  endtask

  task automatic sender_gap();
    if (!steady && !tail_quiet && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
  endtask

  // Lets every expected mean arrive, then gives a run-open beat time to settle.
  task automatic wait_drained();
    while (means_due.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic cfg_write(input cfg_reg_e which, input logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CfgAddrW'(8 * int'(which));
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (which)
      REG_SIZES_LOW:   sizes_lo_m = value;
      REG_SIZES_HIGH:  sizes_hi_m = value;
      REG_GROUP_COUNT: groups_m   = value[CountW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result stalls come in bursts whose length is drawn at random.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      out_if.ready  <= 1'b0;
    end else if (!steady && !tail_quiet && $urandom_range(0, 7) == 0) begin
      stall_left    <= $urandom_range(0, 15);
      out_if.ready  <= 1'b0;
    end else begin
      out_if.ready  <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (means_due.size() == 0) begin
        $display("%0t: unexpected coarse beat: mean %h index %0d last %0b", $time,
                 out_if.coarse_mean, out_if.coarse_index, out_if.last_of_unknown);
        mismatches++;
      end else begin
        head_mean = means_due.pop_front();
        if (out_if.coarse_mean !== head_mean.coarse_mean) begin
          $display("%0t: coarse_mean expected %h actual %h", $time,
                   head_mean.coarse_mean, out_if.coarse_mean);
          mismatches++;
        end
        if (out_if.coarse_index !== head_mean.coarse_index) begin
          $display("%0t: coarse_index expected %0d actual %0d", $time,
                   head_mean.coarse_index, out_if.coarse_index);
          mismatches++;
        end
        if (out_if.last_of_unknown !== head_mean.last_of_unknown) begin
          $display("%0t: last_of_unknown expected %0b actual %0b", $time,
                   head_mean.last_of_unknown, out_if.last_of_unknown);
          mismatches++;
        end
      end
    end
  end

  initial begin
    size_mix_e           mix;
    logic [CfgDataW-1:0] lo;
    logic [CfgDataW-1:0] hi;
    logic [CountW-1:0]   cnt;
    logic [ValueW-1:0]   v;
    int                  n_items;
    int                  phase;
    bit                  lean_negative;

    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_if.valid      = 1'b0;
    in_if.fine_value = '0;
    out_if.ready     = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // After reset every size reads as one and one group is in use, so each
    // value comes straight back as the last group of its unknown.
    plan_mean(32'h7FFF_FFFF, 32'h7FFF_FFFF, 4'd0, 1'b1);
    plan_mean(32'h8000_0000, 32'h8000_0000, 4'd0, 1'b1);
    plan_mean(32'h0000_0000, 32'h0000_0000, 4'd0, 1'b1);
    plan_mean(32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0, 1'b1);
    // Runs of 2, 3 and a zero count that acts as 1.
    plan_write(REG_GROUP_COUNT, 64'd3);
    plan_write(REG_SIZES_LOW, 64'h0000_0000_0000_0302);
    plan_fine(32'h7FFF_FFFF);
    plan_mean(32'h7FFF_FFFF, 32'h7FFF_FFFF, 4'd0, 1'b0);
    plan_fine(32'hFFFF_FFFF);
    plan_fine(32'hFFFF_FFFF);
    plan_mean(32'h0000_0000, 32'h0000_0000, 4'd1, 1'b0);
    plan_mean(32'h8000_0000, 32'h8000_0000, 4'd2, 1'b1);
    plan_fine(32'hFFFF_FFFB);
    plan_mean(32'h0000_0000, 32'hFFFF_FFFE, 4'd0, 1'b0);
    // Shrink the open run below its taken count, then drop the group count
    // under the open group so it closes as the last one.
    plan_fine(32'h0003_0000);
    plan_write(REG_SIZES_LOW, 64'h0000_0000_0000_0102);
    plan_fine(32'h0001_0000);
    plan_write(REG_GROUP_COUNT, 64'd0);
    plan_fine(32'h0000_0007);
    // A group count above the maximum is clamped.
    plan_write(REG_GROUP_COUNT, 64'd31);
    plan_write(REG_SIZES_LOW, 64'h0);
    plan_write(REG_SIZES_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
    repeat (8) plan_fine(pick_fine());

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        in_if.valid <= 1'b0;
        wait_drained();
        cfg_write(plan[i].which, plan[i].data);
      end else begin
        sender_gap();
        push_fine(plan[i].data[ValueW-1:0], plan[i].kind == ROW_MEAN, plan[i].want);
      end
    end

    phase = 0;
    while (fine_sent < 750) begin
      in_if.valid <= 1'b0;
      wait_drained();
      steady     = ($urandom_range(0, 3) == 0);
      tail_quiet = (fine_sent >= 620);
      lean_negative = $urandom_range(0, 1);
      if (phase == 2) begin
        mix = MIX_BIG;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: mix = MIX_SMALL;
          5, 6, 7:       mix = MIX_UNIT;
          default:       mix = MIX_WIDE;
        endcase
      end
      cnt = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                        : 5'($urandom_range(1, 16));
      n_items = $urandom_range(20, 60);
      case (mix)
        MIX_SMALL: begin
          for (int b = 0; b < 8; b++) begin
            lo[b*8 +: 8] = 8'($urandom_range(0, 4));
            hi[b*8 +: 8] = 8'($urandom_range(0, 4));
          end
        end
        MIX_UNIT: begin
          for (int b = 0; b < 8; b++) begin
            lo[b*8 +: 8] = 8'($urandom_range(0, 1));
            hi[b*8 +: 8] = 8'($urandom_range(0, 1));
          end
        end
        MIX_WIDE: begin
          lo = {$urandom, $urandom};
          hi = {$urandom, $urandom};
          n_items = 60;
        end
        default: begin
          // One run of 255 near-extreme values followed by a run of one.
          lo      = 64'h0101_0101_0101_01FF;
          hi      = '1;
          cnt     = 5'd2;
          n_items = 258;
        end
      endcase
      cfg_write(REG_SIZES_LOW, lo);
      cfg_write(REG_SIZES_HIGH, hi);
      cfg_write(REG_GROUP_COUNT, 64'(cnt));
      for (int k = 0; k < n_items; k++) begin
        if (phase == 1 && k == n_items / 2) begin
          in_if.valid <= 1'b0;
          while (means_due.size() != 0) @(negedge clk_i);
          @(negedge clk_i);
        end
        if (mix == MIX_BIG && $urandom_range(0, 3) != 0) begin
          v = lean_negative ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
          v = pick_fine();
        end
        sender_gap();
        push_fine(v, 1'b0, '0);
      end
      phase++;
    end

    in_if.valid <= 1'b0;
    while (means_due.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/gar_pkg.sv
hw/rtl/gar_in_if.sv
hw/rtl/gar_out_if.sv
hw/rtl/gar_div.sv
hw/rtl/group_average_restriction.sv
dv/group_average_restriction_tb.sv
